// ===== src/dlsik_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsik_pkg
// Shared constants, register codes and a saturation helper for the damped least-squares
// inverse-kinematics step.
// ----------------------------------------------------------------------------
package dlsik_pkg;

    // fixed point format
    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DAMP_W     = 25;
    localparam int STEP_W     = 31;
    localparam int TOL_W      = 25;

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 2'd2;

    localparam logic [DAMP_W-1:0] DAMP_RESET     = 25'd6711;
    localparam logic [STEP_W-1:0] MAX_STEP_RESET = 31'd3355443;
    localparam logic [TOL_W-1:0]  TOL_RESET      = 25'd1;

    // quotient limits of the solve, by sign of the numerator
    localparam logic [DATA_W-1:0] LIM_POS = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] LIM_NEG = 32'h8000_0000;

    // saturate a wide signed value to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7fff_ffff;
        lo = -66'sh0_8000_0000;
        if (x > hi) begin
            sat32 = 32'sh7fff_ffff;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== src/dlsik_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsik_div
// Pipelined restoring divider, one quotient bit per stage, with a clamp of
// the quotient to a per-beat limit and a sideband that rides along.
// ----------------------------------------------------------------------------
module dlsik_div #(
    parameter int QW = 32,
    parameter int DW = 64,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_nlo,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_lim,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_v    [0:QW];
    logic [DW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_nlo  [0:QW-1];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_lim  [0:QW];
    logic [QW-1:0] r_quo  [0:QW];
    logic          r_ovf  [0:QW];
    logic [SW-1:0] r_side [0:QW];
    logic          r_ov;
    logic [QW-1:0] r_q;
    logic [SW-1:0] r_so;

    // entry stage, overflow when the top part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rem;
            r_nlo[0]  <= i_nlo;
            r_den[0]  <= i_den;
            r_lim[0]  <= i_lim;
            r_quo[0]  <= '0;
            r_ovf[0]  <= (i_rem >= i_den);
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DW:0] w_t;
        logic [DW:0] w_diff;
        logic        w_ge;

        assign w_t    = {r_rem[k-1], r_nlo[k-1][QW-1]};
        assign w_ge   = (w_t >= {1'b0, r_den[k-1]});
        assign w_diff = w_t - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= r_den[k-1];
                r_lim[k]  <= r_lim[k-1];
                r_quo[k]  <= {r_quo[k-1][QW-2:0], w_ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                    r_nlo[k] <= r_nlo[k-1] << 1;
                end
            end
        end
    end

    // clamp stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q  <= (r_ovf[QW] || (r_quo[QW] > r_lim[QW])) ? r_lim[QW] : r_quo[QW];
            r_so <= r_side[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_quo   = r_q;
    assign o_side  = r_so;

endmodule

// ===== src/dlsik_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsik_sqrt
// Pipelined integer square root, floor of the root, one root bit per stage,
// with a sideband that rides along.
// ----------------------------------------------------------------------------
module dlsik_sqrt #(
    parameter int RW = 32,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int XW = 2 * RW;

    logic          r_v    [0:RW];
    logic [XW-1:0] r_x    [0:RW-1];
    logic [XW-1:0] r_res  [0:RW];
    logic [SW-1:0] r_side [0:RW];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_x;
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // digit by digit, highest root bit first
    for (genvar k = 1; k <= RW; k++) begin : g_stage
        localparam logic [XW-1:0] BITV = {{(XW-1){1'b0}}, 1'b1} << (2 * (RW - k));
        logic [XW-1:0] w_sum;
        logic          w_ge;

        assign w_sum = r_res[k-1] + BITV;
        assign w_ge  = (r_x[k-1] >= w_sum);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k]  <= w_ge ? ((r_res[k-1] >> 1) + BITV) : (r_res[k-1] >> 1);
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < RW) begin : g_x
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= w_ge ? (r_x[k-1] - w_sum) : r_x[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_res[RW][RW-1:0];
    assign o_side  = r_side[RW];

endmodule

// ===== src/damped_least_squares_ik_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_least_squares_ik_step_top
// Damped least-squares joint increment for a planar two-joint arm: solves
// (J*J^T + damping*I) y = e by Cramer's rule, maps dq = J^T y, limits the
// step norm and flags convergence. Signed fixed point throughout.
//
// channel   dir   handshake                    payload
// s_axis    in    i_tvalid / i_tready          i_tdata: err_x, err_y, jac_x_q0,
//                                              jac_x_q1, jac_y_q0, jac_y_q1
// m_axis    out   o_tvalid / o_tready          o_tdata: delta_q0, delta_q1;
//                                              o_tuser: converged
// cfg       in    i_cfg_wr_en                  i_cfg_idx, i_cfg_data
//
// one beat in and one beat out per cycle while the output beat is taken;
// the path holds two bit-serial divider pipelines (34 stages each), the root
// pipeline (33 stages), ten multiply/add stages and the output register.
// all stages move together; when the output beat is not taken the whole
// pipeline holds, so nothing is dropped or repeated.
// synchronous active-low reset clears valid bits and presets the cfg registers.
// ----------------------------------------------------------------------------
module damped_least_squares_ik_step_top
    import dlsik_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_tvalid,
    output logic                  i_tready,
    input  logic [191:0]          i_tdata,   // err_x, err_y, jac_x_q0, jac_x_q1,
                                             // jac_y_q0, jac_y_q1 (32 bits each)
    // master side
    output logic                  o_tvalid,
    input  logic                  o_tready,
    output logic [63:0]           o_tdata,   // delta_q0, delta_q1 (32 bits each)
    output logic                  o_tuser,   // converged
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic                     conv;
        logic                     sing;
        logic                     neg0;
        logic signed [DATA_W-1:0] j00;
        logic signed [DATA_W-1:0] j01;
        logic signed [DATA_W-1:0] j10;
        logic signed [DATA_W-1:0] j11;
    } t_solve_ctx;

    typedef struct packed {
        logic                     conv;
        logic                     sing;
        logic                     scale;
        logic signed [DATA_W-1:0] dq0;
        logic signed [DATA_W-1:0] dq1;
        logic [63:0]              pn0;
        logic [63:0]              pn1;
    } t_step_ctx;

    typedef struct packed {
        logic                     conv;
        logic                     sing;
        logic                     scale;
        logic signed [DATA_W-1:0] dq0;
    } t_scale_ctx;

    logic en;

    // configuration registers
    logic [DAMP_W-1:0]   r_damp;
    logic [STEP_W-1:0]   r_lim;
    logic [TOL_W-1:0]    r_tol;
    logic [2*STEP_W-1:0] r_lim_sq;
    logic [2*TOL_W-1:0]  r_tol_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp <= DAMP_RESET;
            r_lim  <= MAX_STEP_RESET;
            r_tol  <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_DAMPING:  r_damp <= i_cfg_data[DAMP_W-1:0];
                REG_MAX_STEP: r_lim  <= i_cfg_data[STEP_W-1:0];
                REG_TOL:      r_tol  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // squared limits are registered from the registers and follow them in the next cycle
    always_ff @(posedge i_clk) begin
        r_lim_sq <= r_lim * r_lim;
        r_tol_sq <= r_tol * r_tol;
    end

    // stall control: everything advances when the output beat can move
    logic r_out_valid;
    assign en       = !r_out_valid || o_tready;
    assign i_tready = en && i_rst_n;

    // input unpack
    logic signed [DATA_W-1:0] w_ex, w_ey, w_j00, w_j01, w_j10, w_j11;
    assign w_ex  = i_tdata[31:0];
    assign w_ey  = i_tdata[63:32];
    assign w_j00 = i_tdata[95:64];
    assign w_j01 = i_tdata[127:96];
    assign w_j10 = i_tdata[159:128];
    assign w_j11 = i_tdata[191:160];

    // stage 1: products of the inputs
    logic                     r_v1;
    logic signed [DATA_W-1:0] r1_ex, r1_ey, r1_j00, r1_j01, r1_j10, r1_j11;
    logic signed [63:0]       r1_pa0, r1_pa1, r1_pb0, r1_pb1, r1_pc0, r1_pc1;
    logic [63:0]              r1_pe0, r1_pe1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ex  <= w_ex;
            r1_ey  <= w_ey;
            r1_j00 <= w_j00;
            r1_j01 <= w_j01;
            r1_j10 <= w_j10;
            r1_j11 <= w_j11;
            r1_pa0 <= w_j00 * w_j00;
            r1_pa1 <= w_j01 * w_j01;
            r1_pb0 <= w_j00 * w_j10;
            r1_pb1 <= w_j01 * w_j11;
            r1_pc0 <= w_j10 * w_j10;
            r1_pc1 <= w_j11 * w_j11;
            r1_pe0 <= w_ex * w_ex;
            r1_pe1 <= w_ey * w_ey;
        end
    end

    // stage 2: a, b, c of J*J^T plus damping, convergence test
    logic signed [64:0] w_sa, w_sb, w_sc;
    logic signed [65:0] w_a, w_b, w_c, w_damp;
    logic [63:0]        w_e2;

    assign w_sa   = 65'(r1_pa0) + 65'(r1_pa1);
    assign w_sb   = 65'(r1_pb0) + 65'(r1_pb1);
    assign w_sc   = 65'(r1_pc0) + 65'(r1_pc1);
    assign w_damp = $signed({{(66 - DAMP_W){1'b0}}, r_damp});
    assign w_a    = 66'(w_sa >>> FRAC_BITS) + w_damp;
    assign w_b    = 66'(w_sb >>> FRAC_BITS);
    assign w_c    = 66'(w_sc >>> FRAC_BITS) + w_damp;
    assign w_e2   = r1_pe0 + r1_pe1;

    logic                     r_v2, r2_conv;
    logic signed [DATA_W-1:0] r2_a, r2_b, r2_c, r2_ex, r2_ey;
    logic signed [DATA_W-1:0] r2_j00, r2_j01, r2_j10, r2_j11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a    <= sat32(w_a);
            r2_b    <= sat32(w_b);
            r2_c    <= sat32(w_c);
            r2_conv <= (w_e2 < 64'(r_tol_sq));
            r2_ex   <= r1_ex;
            r2_ey   <= r1_ey;
            r2_j00  <= r1_j00;
            r2_j01  <= r1_j01;
            r2_j10  <= r1_j10;
            r2_j11  <= r1_j11;
        end
    end

    // stage 3: products for the determinant and Cramer numerators
    logic                     r_v3, r3_conv;
    logic signed [63:0]       r3_ac, r3_bb, r3_cex, r3_bey, r3_aey, r3_bex;
    logic signed [DATA_W-1:0] r3_j00, r3_j01, r3_j10, r3_j11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ac   <= r2_a * r2_c;
            r3_bb   <= r2_b * r2_b;
            r3_cex  <= r2_c * r2_ex;
            r3_bey  <= r2_b * r2_ey;
            r3_aey  <= r2_a * r2_ey;
            r3_bex  <= r2_b * r2_ex;
            r3_conv <= r2_conv;
            r3_j00  <= r2_j00;
            r3_j01  <= r2_j01;
            r3_j10  <= r2_j10;
            r3_j11  <= r2_j11;
        end
    end

    // stage 4: determinant and numerators
    logic                     r_v4, r4_conv;
    logic signed [64:0]       r4_det, r4_num0, r4_num1;
    logic signed [DATA_W-1:0] r4_j00, r4_j01, r4_j10, r4_j11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_det  <= 65'(r3_ac) - 65'(r3_bb);
            r4_num0 <= 65'(r3_cex) - 65'(r3_bey);
            r4_num1 <= 65'(r3_aey) - 65'(r3_bex);
            r4_conv <= r3_conv;
            r4_j00  <= r3_j00;
            r4_j01  <= r3_j01;
            r4_j10  <= r3_j10;
            r4_j11  <= r3_j11;
        end
    end

    // stage 5: magnitudes and signs, singular check
    logic       r_v5, r5_neg0, r5_neg1;
    logic [63:0] r5_mag0, r5_mag1, r5_det;
    t_solve_ctx r5_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_neg0     <= r4_num0[64];
            r5_neg1     <= r4_num1[64];
            r5_mag0     <= r4_num0[64] ? 64'(-r4_num0) : r4_num0[63:0];
            r5_mag1     <= r4_num1[64] ? 64'(-r4_num1) : r4_num1[63:0];
            r5_det      <= r4_det[63:0];
            r5_ctx.conv <= r4_conv;
            r5_ctx.sing <= r4_det[64] || (r4_det == '0);
            r5_ctx.neg0 <= r4_num0[64];
            r5_ctx.j00  <= r4_j00;
            r5_ctx.j01  <= r4_j01;
            r5_ctx.j10  <= r4_j10;
            r5_ctx.j11  <= r4_j11;
        end
    end

    // solve: y = num * 2^FRAC_BITS / det, clamped by sign
    logic                       w_d0_valid, w_d1_valid;
    logic [DATA_W-1:0]          w_q0, w_q1;
    logic [$bits(t_solve_ctx)-1:0] w_d0_side;
    logic                       w_d1_neg;
    t_solve_ctx                 w_sctx;

    dlsik_div #(
        .QW (DATA_W),
        .DW (64),
        .SW ($bits(t_solve_ctx))
    ) u_div_y0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_rem   (r5_mag0 >> (DATA_W - FRAC_BITS)),
        .i_nlo   (DATA_W'(r5_mag0 << FRAC_BITS)),
        .i_den   (r5_det),
        .i_lim   (r5_neg0 ? LIM_NEG : LIM_POS),
        .i_side  (r5_ctx),
        .o_valid (w_d0_valid),
        .o_quo   (w_q0),
        .o_side  (w_d0_side)
    );

    dlsik_div #(
        .QW (DATA_W),
        .DW (64),
        .SW (1)
    ) u_div_y1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_rem   (r5_mag1 >> (DATA_W - FRAC_BITS)),
        .i_nlo   (DATA_W'(r5_mag1 << FRAC_BITS)),
        .i_den   (r5_det),
        .i_lim   (r5_neg1 ? LIM_NEG : LIM_POS),
        .i_side  (r5_neg1),
        .o_valid (w_d1_valid),
        .o_quo   (w_q1),
        .o_side  (w_d1_neg)
    );

    assign w_sctx = t_solve_ctx'(w_d0_side);

    // stage 6: apply signs to y
    logic                     r_v6, r6_conv, r6_sing;
    logic signed [DATA_W-1:0] r6_y0, r6_y1, r6_j00, r6_j01, r6_j10, r6_j11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= w_d0_valid && w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_y0   <= w_sctx.neg0 ? (DATA_W'(0) - w_q0) : w_q0;
            r6_y1   <= w_d1_neg ? (DATA_W'(0) - w_q1) : w_q1;
            r6_conv <= w_sctx.conv;
            r6_sing <= w_sctx.sing;
            r6_j00  <= w_sctx.j00;
            r6_j01  <= w_sctx.j01;
            r6_j10  <= w_sctx.j10;
            r6_j11  <= w_sctx.j11;
        end
    end

    // stage 7: J^T y products
    logic               r_v7, r7_conv, r7_sing;
    logic signed [63:0] r7_m00, r7_m10, r7_m01, r7_m11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_m00  <= r6_j00 * r6_y0;
            r7_m10  <= r6_j10 * r6_y1;
            r7_m01  <= r6_j01 * r6_y0;
            r7_m11  <= r6_j11 * r6_y1;
            r7_conv <= r6_conv;
            r7_sing <= r6_sing;
        end
    end

    // stage 8: raw increment, floored and saturated
    logic signed [64:0] w_s0, w_s1;
    assign w_s0 = 65'(r7_m00) + 65'(r7_m10);
    assign w_s1 = 65'(r7_m01) + 65'(r7_m11);

    logic                     r_v8, r8_conv, r8_sing;
    logic signed [DATA_W-1:0] r8_dq0, r8_dq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_dq0  <= sat32(66'(w_s0 >>> FRAC_BITS));
            r8_dq1  <= sat32(66'(w_s1 >>> FRAC_BITS));
            r8_conv <= r7_conv;
            r8_sing <= r7_sing;
        end
    end

    // stage 9: squares and |dq| * limit
    logic [DATA_W-1:0] w_mag0, w_mag1;
    assign w_mag0 = r8_dq0[DATA_W-1] ? (DATA_W'(0) - r8_dq0) : r8_dq0;
    assign w_mag1 = r8_dq1[DATA_W-1] ? (DATA_W'(0) - r8_dq1) : r8_dq1;

    logic                     r_v9, r9_conv, r9_sing;
    logic [63:0]              r9_sq0, r9_sq1, r9_pn0, r9_pn1;
    logic signed [DATA_W-1:0] r9_dq0, r9_dq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sq0  <= r8_dq0 * r8_dq0;
            r9_sq1  <= r8_dq1 * r8_dq1;
            r9_pn0  <= w_mag0 * r_lim;
            r9_pn1  <= w_mag1 * r_lim;
            r9_dq0  <= r8_dq0;
            r9_dq1  <= r8_dq1;
            r9_conv <= r8_conv;
            r9_sing <= r8_sing;
        end
    end

    // stage 10: squared norm and the limit test
    logic [63:0] w_n2;
    assign w_n2 = r9_sq0 + r9_sq1;

    logic        r_v10;
    logic [63:0] r10_n2;
    t_step_ctx   r10_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_n2        <= w_n2;
            r10_ctx.conv  <= r9_conv;
            r10_ctx.sing  <= r9_sing;
            r10_ctx.scale <= (w_n2 > 64'(r_lim_sq));
            r10_ctx.dq0   <= r9_dq0;
            r10_ctx.dq1   <= r9_dq1;
            r10_ctx.pn0   <= r9_pn0;
            r10_ctx.pn1   <= r9_pn1;
        end
    end

    // norm of the increment
    logic                         w_rt_valid;
    logic [DATA_W-1:0]            w_norm;
    logic [$bits(t_step_ctx)-1:0] w_rt_side;
    t_step_ctx                    w_tctx;
    t_scale_ctx                   w_kin;

    dlsik_sqrt #(
        .RW (DATA_W),
        .SW ($bits(t_step_ctx))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v10),
        .i_x     (r10_n2),
        .i_side  (r10_ctx),
        .o_valid (w_rt_valid),
        .o_root  (w_norm),
        .o_side  (w_rt_side)
    );

    assign w_tctx      = t_step_ctx'(w_rt_side);
    assign w_kin.conv  = w_tctx.conv;
    assign w_kin.sing  = w_tctx.sing;
    assign w_kin.scale = w_tctx.scale;
    assign w_kin.dq0   = w_tctx.dq0;

    // scaled magnitude = |dq| * limit / norm, below 2^32 whenever used
    logic                          w_k0_valid, w_k1_valid;
    logic [DATA_W-1:0]             w_k0, w_k1;
    logic [$bits(t_scale_ctx)-1:0] w_k0_side;
    logic [DATA_W-1:0]             w_k1_dq;
    t_scale_ctx                    w_kctx;
    logic signed [DATA_W-1:0]      w_dq1_out;

    dlsik_div #(
        .QW (DATA_W),
        .DW (DATA_W),
        .SW ($bits(t_scale_ctx))
    ) u_div_k0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_rt_valid),
        .i_rem   (w_tctx.pn0[63:32]),
        .i_nlo   (w_tctx.pn0[31:0]),
        .i_den   (w_norm),
        .i_lim   ('1),
        .i_side  (w_kin),
        .o_valid (w_k0_valid),
        .o_quo   (w_k0),
        .o_side  (w_k0_side)
    );

    dlsik_div #(
        .QW (DATA_W),
        .DW (DATA_W),
        .SW (DATA_W)
    ) u_div_k1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_rt_valid),
        .i_rem   (w_tctx.pn1[63:32]),
        .i_nlo   (w_tctx.pn1[31:0]),
        .i_den   (w_norm),
        .i_lim   ('1),
        .i_side  (w_tctx.dq1),
        .o_valid (w_k1_valid),
        .o_quo   (w_k1),
        .o_side  (w_k1_dq)
    );

    assign w_kctx    = t_scale_ctx'(w_k0_side);
    assign w_dq1_out = w_k1_dq;

    // output register: pick scaled, raw or zero increment
    logic signed [DATA_W-1:0] w_out0, w_out1;
    logic                     r_out_conv;
    logic [DATA_W-1:0]        r_out0, r_out1;

    always_comb begin
        if (w_kctx.conv || w_kctx.sing) begin
            w_out0 = '0;
            w_out1 = '0;
        end else if (w_kctx.scale) begin
            w_out0 = w_kctx.dq0[DATA_W-1] ? (DATA_W'(0) - w_k0) : w_k0;
            w_out1 = w_dq1_out[DATA_W-1] ? (DATA_W'(0) - w_k1) : w_k1;
        end else begin
            w_out0 = w_kctx.dq0;
            w_out1 = w_dq1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_k0_valid && w_k1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out0     <= w_out0;
            r_out1     <= w_out1;
            r_out_conv <= w_kctx.conv;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out1, r_out0};
    assign o_tuser  = r_out_conv;

endmodule

// ===== src/dlsik_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlsik_chk
// Port-level checks on the inverse-kinematics step block, bound to the top.
// ----------------------------------------------------------------------------
module dlsik_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tready,
    input logic        o_tvalid,
    input logic        o_tready,
    input logic [63:0] o_tdata,
    input logic        o_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !o_tready |=> o_tvalid && $stable(o_tdata) && $stable(o_tuser))
        else $error("output beat changed while stalled");

    // a converged beat carries a zero increment
    a_conv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_tuser |-> o_tdata == '0)
        else $error("converged beat with nonzero increment");

    // input side is open whenever the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tready == (!o_tvalid || o_tready))
        else $error("input ready does not follow output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tvalid)
        else $error("output valid right after reset");

endmodule

bind damped_least_squares_ik_step_top dlsik_chk u_dlsik_chk (.*);

// ===== sim/damped_least_squares_ik_step_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_least_squares_ik_step_top_tb
// Self-checking bench for the two-joint damped least-squares step. A directed
// table covers zero and full-scale errors, singular Jacobians and step
// clamping; random beats follow under several register settings. Every
// output beat is compared with its table row or a bit-exact solver kept in
// the bench, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module damped_least_squares_ik_step_top_tb;
    import dlsik_pkg::*;

    localparam int LATENCY     = 112;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int FB          = 24;

    typedef logic signed [131:0] t_wide;

    typedef struct packed {
        logic [31:0] dq0;
        logic [31:0] dq1;
        logic        conv;
    } t_delta;

    typedef struct {
        logic [191:0] data;
        bit           typed;
        t_delta       want;
    } t_offer;

    typedef struct {
        logic [31:0] ex, ey, jx0, jx1, jy0, jy1;
        bit          typed;
        logic [31:0] dq0, dq1;
        logic        conv;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_tvalid = 1'b0;
    logic                  i_tready;
    logic [191:0]          i_tdata = '0;
    logic                  o_tvalid;
    logic                  o_tready = 1'b0;
    logic [63:0]           o_tdata;
    logic                  o_tuser;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    damped_least_squares_ik_step_top dut (.*);

    // bench copy of the registers
    logic [DAMP_W-1:0] damp_q = DAMP_RESET;
    logic [STEP_W-1:0] step_q = MAX_STEP_RESET;
    logic [TOL_W-1:0]  tol_q  = TOL_RESET;

    t_offer offered[$];
    t_delta pending[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_req = 1'b0;
    bit     no_gaps = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // bit-exact solver
    // ------------------------------------------------------------------------
    function automatic t_wide clamp32(t_wide x);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< 31) - t_wide'(1);
        lo = -(t_wide'(1) <<< 31);
        if (x > hi) begin
            return hi;
        end
        if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    function automatic t_wide frac_div(t_wide num, t_wide det);
        t_wide mag, q, lim;
        mag = (num < 0) ? -num : num;
        lim = (num < 0) ? (t_wide'(1) <<< 31) : ((t_wide'(1) <<< 31) - t_wide'(1));
        q = (mag <<< FB) / det;
        if (q > lim) begin
            q = lim;
        end
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_delta solve_step(logic [191:0] d);
        t_wide ex, ey, j00, j01, j10, j11, a, b, c, det, y0, y1, dq0, dq1;
        t_wide e2, tol, n2, lim, dmp, nrm;
        t_delta r;
        ex  = $signed(d[31:0]);
        ey  = $signed(d[63:32]);
        j00 = $signed(d[95:64]);
        j01 = $signed(d[127:96]);
        j10 = $signed(d[159:128]);
        j11 = $signed(d[191:160]);
        tol = tol_q;
        lim = step_q;
        dmp = damp_q;
        r = '0;
        e2 = ex * ex + ey * ey;
        if (e2 < tol * tol) begin
            r.conv = 1'b1;
            return r;
        end
        a = clamp32(((j00 * j00 + j01 * j01) >>> FB) + dmp);
        b = clamp32((j00 * j10 + j01 * j11) >>> FB);
        c = clamp32(((j10 * j10 + j11 * j11) >>> FB) + dmp);
        det = a * c - b * b;
        if (det <= 0) begin
            return r;
        end
        y0 = frac_div(c * ex - b * ey, det);
        y1 = frac_div(a * ey - b * ex, det);
        dq0 = clamp32((j00 * y0 + j10 * y1) >>> FB);
        dq1 = clamp32((j01 * y0 + j11 * y1) >>> FB);
        n2 = dq0 * dq0 + dq1 * dq1;
        if (n2 > lim * lim) begin
            nrm = root_floor(n2[63:0]);
            dq0 = dq0 * lim / nrm;
            dq1 = dq1 * lim / nrm;
        end
        r.dq0 = dq0[31:0];
        r.dq1 = dq1[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // expectation on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_offer o;
        t_delta w;
        if (i_rst_n && i_tvalid && i_tready) begin
            o = offered.pop_front();
            pending.push_back(o.typed ? o.want : solve_step(o.data));
        end
        if (i_rst_n && o_tvalid && o_tready) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", o_tdata[31:0], 32'h0);
            end else begin
                w = pending.pop_front();
                if (o_tdata[31:0] !== w.dq0) report_mismatch("delta_q0", o_tdata[31:0], w.dq0);
                if (o_tdata[63:32] !== w.dq1) report_mismatch("delta_q1", o_tdata[63:32], w.dq1);
                if (o_tuser !== w.conv) report_mismatch("converged", 32'(o_tuser), 32'(w.conv));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial begin
        int hold_cnt;
        int mode;
        int left;
        hold_cnt = 0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 400;
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                o_tready <= 1'b0;
            end else begin
                case (mode)
                    0: o_tready <= 1'b1;
                    1: o_tready <= ($urandom_range(0, 1) != 0);
                    2: o_tready <= ($urandom_range(0, 7) != 0);
                    default: o_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [191:0] d, bit typed, t_delta want, int gap);
        t_offer o;
        o.data = d;
        o.typed = typed;
        o.want = want;
        offered.push_back(o);
        i_tvalid <= 1'b1;
        i_tdata <= d;
        @(posedge i_clk);
        while (!i_tready) @(posedge i_clk);
        if (gap > 0) begin
            i_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || offered.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // register write only with the pipeline empty
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_tvalid <= 1'b0;
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_DAMPING:  damp_q = val[DAMP_W-1:0];
            REG_MAX_STEP: step_q = val[STEP_W-1:0];
            REG_TOL:      tol_q  = val[TOL_W-1:0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_field(int kind);
        int k;
        case (kind)
            0: return $urandom;
            1: begin
                k = $urandom_range(0, 30);
                return $urandom_range(0, 1) ? ($urandom & ((32'd1 << k) - 1))
                                            : -($urandom & ((32'd1 << k) - 1));
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    3: return 32'h0100_0000;
                    default: return 32'hff00_0000;
                endcase
            end
            // plausible arm: within +-1.0
            default: return $signed($urandom & 32'h01ff_ffff) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic [191:0] rand_item();
        logic [191:0] d;
        int jk, ek;
        int pick;
        pick = $urandom_range(0, 9);
        jk = (pick < 6) ? 3 : (pick < 8) ? 1 : (pick == 8) ? 0 : 2;
        ek = (pick < 4) ? 1 : jk;
        d[31:0]    = rand_field(ek);
        d[63:32]   = rand_field(ek);
        for (int f = 2; f < 6; f++) d[f*32 +: 32] = rand_field(jk);
        return d;
    endfunction

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && n > 0; i++) begin
                n--;
                send_beat(rand_item(), 1'b0, '0,
                          (no_gaps || i + 1 < burst) ? 0 : $urandom_range(0, 6));
            end
        end
    endtask

    localparam logic [31:0] ONE = 32'h0100_0000;
    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;

    t_row table_rows[] = '{
        // all zero: converged at reset tolerance
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1},
        // zero Jacobian, full-scale errors: no motion
        '{MAXP, MAXP, 0, 0, 0, 0, 1, 0, 0, 0},
        '{MINN, MINN, 0, 0, 0, 0, 1, 0, 0, 0},
        '{MAXP, MINN, 0, 0, 0, 0, 1, 0, 0, 0},
        // saturated rank-one Jacobians: singular system
        '{ONE, ONE, MAXP, MAXP, MAXP, MAXP, 1, 0, 0, 0},
        '{ONE, MINN, MINN, MINN, MINN, MINN, 1, 0, 0, 0},
        // identity Jacobian, assorted errors
        '{ONE, 0, ONE, 0, 0, ONE, 0, 0, 0, 0},
        '{32'd1000, 32'hffff_fc18, ONE, 0, 0, ONE, 0, 0, 0, 0},
        '{1, 1, ONE, 0, 0, ONE, 0, 0, 0, 0},
        '{MAXP, MINN, ONE, 0, 0, ONE, 0, 0, 0, 0},
        // mixed extremes
        '{MINN, MAXP, MAXP, 0, 0, MINN, 0, 0, 0, 0},
        '{32'h0040_0000, 32'hffc0_0000, MINN, MAXP, MAXP, MINN, 0, 0, 0, 0},
        '{32'h0010_0000, 32'h0020_0000, 32'h00c0_0000, 32'hff80_0000,
          32'h0080_0000, 32'h0140_0000, 0, 0, 0, 0},
        '{32'hffff_ffff, 32'h0000_0001, 32'h0000_0100, 32'h0000_0100,
          32'hffff_ff00, 32'h0000_0100, 0, 0, 0, 0}
    };

    initial begin
        t_delta w;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        foreach (table_rows[r]) begin
            w.dq0 = table_rows[r].dq0;
            w.dq1 = table_rows[r].dq1;
            w.conv = table_rows[r].conv;
            send_beat({table_rows[r].jy1, table_rows[r].jy0, table_rows[r].jx1,
                       table_rows[r].jx0, table_rows[r].ey, table_rows[r].ex},
                      table_rows[r].typed, w, $urandom_range(0, 2));
        end

        // no damping: rank-one unit Jacobian is singular
        write_reg(REG_DAMPING, 31'd0);
        w = '0;
        send_beat({ONE, ONE, ONE, ONE, 32'd5, ONE}, 1'b1, w, 0);
        send_beat({ONE, 32'd0, 32'd0, ONE, ONE, 32'd7}, 1'b0, w, 1);
        random_phase(200);

        // full tolerance and damping, with unused upper bits set
        write_reg(REG_TOL, 31'h7fff_ffff);
        write_reg(REG_DAMPING, 31'h7fff_ffff);
        w = '0;
        w.conv = 1'b1;
        send_beat({ONE, 32'd0, 32'd0, ONE, 32'd100, 32'd100}, 1'b1, w, 0);
        random_phase(200);

        // zero step limit and zero tolerance
        write_reg(REG_MAX_STEP, 31'd0);
        write_reg(REG_TOL, 31'd0);
        random_phase(200);

        // widest step limit, long receiver hold-off with back-to-back input
        write_reg(REG_MAX_STEP, 31'h7fff_ffff);
        write_reg(REG_DAMPING, 31'd6711);
        hold_req = 1'b1;
        no_gaps = 1'b1;
        random_phase(400);
        no_gaps = 1'b0;

        // sender pause until everything is back
        i_tvalid <= 1'b0;
        drain();

        // typical settings
        write_reg(REG_MAX_STEP, 31'd3355443);
        write_reg(REG_TOL, 31'd16777);
        write_reg(REG_DAMPING, 31'h0100_0000);
        random_phase(400);

        write_reg(REG_DAMPING, 31'd1);
        write_reg(REG_MAX_STEP, 31'd1);
        write_reg(REG_TOL, 31'd1);
        random_phase(430);

        i_tvalid <= 1'b0;
        drain();
        if (errors == 0 && pending.size() == 0 && offered.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
